// ----- rtl/core/erm_pkg.sv -----
// Shared constants, types and arithmetic helpers of the Euler rotation matrix block.
`default_nettype none
package erm_pkg;

    localparam int OUT_FRAC_BITS = 14;
    localparam int CORDIC_STAGES = 16;
    // The number of rotation cells is capped at 32.
    localparam int NUM_CELLS = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

    localparam int ANGLE_W = 16;
    localparam int ELEM_W  = 16;
    localparam int XY_W    = 34;
    localparam int Z_W     = 33;
    localparam int SC_W    = 32;
    localparam int IDX_W   = 5;
    localparam int SUM_W   = 34;

    localparam int TURN_UNITS    = 23040;
    localparam int QUARTER_UNITS = 5760;
    localparam int CORDIC_GAIN   = 652032874;

    localparam int OUT_SHIFT = 30 - OUT_FRAC_BITS;
    localparam longint OUT_RND = (OUT_FRAC_BITS >= 30) ? 64'sd0 :
                                 (64'sd1 <<< (29 - OUT_FRAC_BITS));
    localparam longint OUT_LIM = 64'sd1 <<< OUT_FRAC_BITS;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [1:0]             q;
    } cordic_lane_t;

    typedef struct packed {
        cordic_lane_t ax;
        cordic_lane_t ay;
        cordic_lane_t az;
    } cordic_trio_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] e00;
        logic signed [ELEM_W-1:0] e01;
        logic signed [ELEM_W-1:0] e02;
        logic signed [ELEM_W-1:0] e10;
        logic signed [ELEM_W-1:0] e11;
        logic signed [ELEM_W-1:0] e12;
        logic signed [ELEM_W-1:0] e20;
        logic signed [ELEM_W-1:0] e21;
        logic signed [ELEM_W-1:0] e22;
    } elem_set_t;

    // Arctangent of 2^-i in degrees scaled by 2^24.
    function automatic logic signed [Z_W-1:0] atan_deg24(input logic [IDX_W-1:0] i);
        logic signed [Z_W-1:0] t;
        case (i)
            5'd0:    t = 33'sd754974720;
            5'd1:    t = 33'sd445687602;
            5'd2:    t = 33'sd235489088;
            5'd3:    t = 33'sd119537938;
            5'd4:    t = 33'sd60000934;
            5'd5:    t = 33'sd30029717;
            5'd6:    t = 33'sd15018523;
            5'd7:    t = 33'sd7509720;
            5'd8:    t = 33'sd3754917;
            5'd9:    t = 33'sd1877466;
            5'd10:   t = 33'sd938734;
            5'd11:   t = 33'sd469367;
            5'd12:   t = 33'sd234684;
            5'd13:   t = 33'sd117342;
            5'd14:   t = 33'sd58671;
            5'd15:   t = 33'sd29335;
            5'd16:   t = 33'sd14668;
            5'd17:   t = 33'sd7334;
            5'd18:   t = 33'sd3667;
            5'd19:   t = 33'sd1833;
            5'd20:   t = 33'sd917;
            5'd21:   t = 33'sd458;
            5'd22:   t = 33'sd229;
            5'd23:   t = 33'sd115;
            5'd24:   t = 33'sd57;
            5'd25:   t = 33'sd29;
            5'd26:   t = 33'sd14;
            5'd27:   t = 33'sd7;
            5'd28:   t = 33'sd4;
            5'd29:   t = 33'sd2;
            5'd30:   t = 33'sd1;
            default: t = 33'sd0;
        endcase
        return t;
    endfunction

    // Q30 product with round half up.
    function automatic logic signed [SC_W-1:0] mul30(input logic signed [SC_W-1:0] a,
                                                     input logic signed [SC_W-1:0] b);
        logic signed [63:0] p;
        p = a * b;
        p = p + 64'sd536870912;
        return p[61:30];
    endfunction

    // Round a Q30 value to the output fraction and saturate to plus or minus one.
    function automatic logic signed [ELEM_W-1:0] to_out(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W:0] t;
        t = (SUM_W+1)'(v) + (SUM_W+1)'(OUT_RND);
        t = t >>> OUT_SHIFT;
        if (t > (SUM_W+1)'(OUT_LIM)) begin
            t = (SUM_W+1)'(OUT_LIM);
        end
        if (t < -((SUM_W+1)'(OUT_LIM))) begin
            t = -((SUM_W+1)'(OUT_LIM));
        end
        return t[ELEM_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/erm_if.sv -----
// Request channel interfaces for the angle input and the matrix output.
`default_nettype none
interface erm_angle_if;
    logic valid;
    logic ready;
    logic signed [erm_pkg::ANGLE_W-1:0] angle_x;
    logic signed [erm_pkg::ANGLE_W-1:0] angle_y;
    logic signed [erm_pkg::ANGLE_W-1:0] angle_z;
    modport source (output valid, output angle_x, output angle_y, output angle_z,
                    input ready);
    modport sink (input valid, input angle_x, input angle_y, input angle_z,
                  output ready);
endinterface

interface erm_matrix_if;
    logic valid;
    logic ready;
    logic signed [erm_pkg::ELEM_W-1:0] elem_00;
    logic signed [erm_pkg::ELEM_W-1:0] elem_01;
    logic signed [erm_pkg::ELEM_W-1:0] elem_02;
    logic signed [erm_pkg::ELEM_W-1:0] elem_10;
    logic signed [erm_pkg::ELEM_W-1:0] elem_11;
    logic signed [erm_pkg::ELEM_W-1:0] elem_12;
    logic signed [erm_pkg::ELEM_W-1:0] elem_20;
    logic signed [erm_pkg::ELEM_W-1:0] elem_21;
    logic signed [erm_pkg::ELEM_W-1:0] elem_22;
    modport source (output valid, output elem_00, output elem_01, output elem_02,
                    output elem_10, output elem_11, output elem_12,
                    output elem_20, output elem_21, output elem_22, input ready);
    modport sink (input valid, input elem_00, input elem_01, input elem_02,
                  input elem_10, input elem_11, input elem_12,
                  input elem_20, input elem_21, input elem_22, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/erm_reduce.sv -----
// Angle reduction modulo one turn and quadrant split, two pipeline stages.
`default_nettype none
module erm_reduce (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [erm_pkg::ANGLE_W-1:0]  angle_x,
    input  wire logic signed [erm_pkg::ANGLE_W-1:0]  angle_y,
    input  wire logic signed [erm_pkg::ANGLE_W-1:0]  angle_z,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output erm_pkg::cordic_trio_t                    out_data
);

    logic        v1_reg, v2_reg;
    logic        en1, en2;
    logic [14:0] ax_reg, ay_reg, az_reg;
    erm_pkg::cordic_trio_t trio_reg;

    function automatic logic [14:0] wrap(input logic signed [erm_pkg::ANGLE_W-1:0] a);
        logic signed [17:0] w;
        logic signed [17:0] r;
        w = 18'(a);
        if (w < -18'sd23040) begin
            r = w + 18'sd46080;
        end else if (w < 18'sd0) begin
            r = w + 18'sd23040;
        end else if (w >= 18'sd23040) begin
            r = w - 18'sd23040;
        end else begin
            r = w;
        end
        return r[14:0];
    endfunction

    function automatic erm_pkg::cordic_lane_t seed(input logic [14:0] a);
        erm_pkg::cordic_lane_t l;
        logic [14:0] r;
        if (a >= 15'(3 * erm_pkg::QUARTER_UNITS)) begin
            l.q = 2'd3;
            r   = a - 15'(3 * erm_pkg::QUARTER_UNITS);
        end else if (a >= 15'(2 * erm_pkg::QUARTER_UNITS)) begin
            l.q = 2'd2;
            r   = a - 15'(2 * erm_pkg::QUARTER_UNITS);
        end else if (a >= 15'(erm_pkg::QUARTER_UNITS)) begin
            l.q = 2'd1;
            r   = a - 15'(erm_pkg::QUARTER_UNITS);
        end else begin
            l.q = 2'd0;
            r   = a;
        end
        l.z = $signed({2'b00, r[12:0], 18'b0});
        l.x = erm_pkg::XY_W'(erm_pkg::CORDIC_GAIN);
        l.y = '0;
        return l;
    endfunction

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= in_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (en1 && in_valid) begin
            ax_reg <= wrap(angle_x);
            ay_reg <= wrap(angle_y);
            az_reg <= wrap(angle_z);
        end
        if (en2 && v1_reg) begin
            trio_reg.ax <= seed(ax_reg);
            trio_reg.ay <= seed(ay_reg);
            trio_reg.az <= seed(az_reg);
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = trio_reg;

endmodule
`default_nettype wire

// ----- rtl/core/erm_cordic_cell.sv -----
// One CORDIC rotation for all three angles, with its own pipeline register.
`default_nettype none
module erm_cordic_cell (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [erm_pkg::IDX_W-1:0]         idx,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire erm_pkg::cordic_trio_t             in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output erm_pkg::cordic_trio_t                  out_data
);

    logic                  valid_reg;
    logic                  en;
    erm_pkg::cordic_trio_t data_reg;

    function automatic erm_pkg::cordic_lane_t rotate(input erm_pkg::cordic_lane_t l,
                                                     input logic [erm_pkg::IDX_W-1:0] i);
        erm_pkg::cordic_lane_t n;
        logic signed [erm_pkg::XY_W-1:0] dx;
        logic signed [erm_pkg::XY_W-1:0] dy;
        logic signed [erm_pkg::Z_W-1:0]  t;
        dx = l.y >>> i;
        dy = l.x >>> i;
        t  = erm_pkg::atan_deg24(i);
        n.q = l.q;
        if (!l.z[erm_pkg::Z_W-1]) begin
            n.x = l.x - dx;
            n.y = l.y + dy;
            n.z = l.z - t;
        end else begin
            n.x = l.x + dx;
            n.y = l.y - dy;
            n.z = l.z + t;
        end
        return n;
    endfunction

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en && in_valid) begin
            data_reg.ax <= rotate(in_data.ax, idx);
            data_reg.ay <= rotate(in_data.ay, idx);
            data_reg.az <= rotate(in_data.az, idx);
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

// ----- rtl/core/erm_combine.sv -----
// Quadrant unfolding, two product stages and output rounding of the matrix.
`default_nettype none
module erm_combine (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire erm_pkg::cordic_trio_t  in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output erm_pkg::elem_set_t          out_data
);

    typedef logic signed [erm_pkg::SC_W-1:0] sc_t;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    sc_t sx_reg, cx_reg, sy_reg, cy_reg, sz_reg, cz_reg;
    sc_t sxsy_reg, cxsy_reg, p00_reg, p01_reg, p12_reg, p22_reg;
    sc_t cxsz_reg, cxcz_reg, sxsz_reg, sxcz_reg, nsy_reg, sz2_reg, cz2_reg;
    sc_t q00_reg, q01_reg, q12_reg, q22_reg, qcxsz_reg, qcxcz_reg, qsxsz_reg, qsxcz_reg;
    sc_t qnsy_reg, m10_reg, m11_reg, m20_reg, m21_reg;
    erm_pkg::elem_set_t elem_reg;

    function automatic sc_t clamp_unit(input logic signed [erm_pkg::XY_W-1:0] v);
        sc_t r;
        if (v > 34'sd1073741824) begin
            r = 32'sd1073741824;
        end else if (v < -34'sd1073741824) begin
            r = -32'sd1073741824;
        end else begin
            r = v[erm_pkg::SC_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [2*erm_pkg::SC_W-1:0] unfold(input erm_pkg::cordic_lane_t l);
        sc_t s;
        sc_t c;
        sc_t so;
        sc_t co;
        s = clamp_unit(l.y);
        c = clamp_unit(l.x);
        case (l.q)
            2'd0:    begin so = s;  co = c;  end
            2'd1:    begin so = c;  co = -s; end
            2'd2:    begin so = -s; co = -c; end
            default: begin so = -c; co = s;  end
        endcase
        return {so, co};
    endfunction

    function automatic logic signed [erm_pkg::SUM_W-1:0] ext(input sc_t v);
        return erm_pkg::SUM_W'(v);
    endfunction

    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= in_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (en4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (en1 && in_valid) begin
            {sx_reg, cx_reg} <= unfold(in_data.ax);
            {sy_reg, cy_reg} <= unfold(in_data.ay);
            {sz_reg, cz_reg} <= unfold(in_data.az);
        end
        if (en2 && v1_reg) begin
            sxsy_reg <= erm_pkg::mul30(sx_reg, sy_reg);
            cxsy_reg <= erm_pkg::mul30(cx_reg, sy_reg);
            p00_reg  <= erm_pkg::mul30(cy_reg, cz_reg);
            p01_reg  <= erm_pkg::mul30(cy_reg, sz_reg);
            p12_reg  <= erm_pkg::mul30(sx_reg, cy_reg);
            p22_reg  <= erm_pkg::mul30(cx_reg, cy_reg);
            cxsz_reg <= erm_pkg::mul30(cx_reg, sz_reg);
            cxcz_reg <= erm_pkg::mul30(cx_reg, cz_reg);
            sxsz_reg <= erm_pkg::mul30(sx_reg, sz_reg);
            sxcz_reg <= erm_pkg::mul30(sx_reg, cz_reg);
            nsy_reg  <= -sy_reg;
            sz2_reg  <= sz_reg;
            cz2_reg  <= cz_reg;
        end
        if (en3 && v2_reg) begin
            m10_reg   <= erm_pkg::mul30(sxsy_reg, cz2_reg);
            m11_reg   <= erm_pkg::mul30(sxsy_reg, sz2_reg);
            m20_reg   <= erm_pkg::mul30(cxsy_reg, cz2_reg);
            m21_reg   <= erm_pkg::mul30(cxsy_reg, sz2_reg);
            q00_reg   <= p00_reg;
            q01_reg   <= p01_reg;
            q12_reg   <= p12_reg;
            q22_reg   <= p22_reg;
            qcxsz_reg <= cxsz_reg;
            qcxcz_reg <= cxcz_reg;
            qsxsz_reg <= sxsz_reg;
            qsxcz_reg <= sxcz_reg;
            qnsy_reg  <= nsy_reg;
        end
        if (en4 && v3_reg) begin
            elem_reg.e00 <= erm_pkg::to_out(ext(q00_reg));
            elem_reg.e01 <= erm_pkg::to_out(ext(q01_reg));
            elem_reg.e02 <= erm_pkg::to_out(ext(qnsy_reg));
            elem_reg.e10 <= erm_pkg::to_out(ext(m10_reg) - ext(qcxsz_reg));
            elem_reg.e11 <= erm_pkg::to_out(ext(m11_reg) + ext(qcxcz_reg));
            elem_reg.e12 <= erm_pkg::to_out(ext(q12_reg));
            elem_reg.e20 <= erm_pkg::to_out(ext(m20_reg) + ext(qsxsz_reg));
            elem_reg.e21 <= erm_pkg::to_out(ext(m21_reg) - ext(qsxcz_reg));
            elem_reg.e22 <= erm_pkg::to_out(ext(q22_reg));
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = elem_reg;

endmodule
`default_nettype wire

// ----- rtl/core/euler_rotation_matrix.sv -----
// Top level: Euler angle triple in, 3x3 rotation matrix out, fully pipelined.
// Usage:
//   The angles channel carries one request per angle triple (angle_x, angle_y,
//   angle_z, signed degrees times 64). Any 16-bit pattern is legal; angles
//   are reduced modulo one turn. The matrix channel returns one request per
//   triple with the nine Q1.14 elements, in the order the triples came in.
//   A request moves at a rising clock edge where valid and ready are high.
// Pipeline and throughput:
//   Angle reduction, one CORDIC cell per rotation (sixteen cells in the
//   default build), unfold, the product stages and rounding, each behind
//   its own registers.
//   One triple is accepted per cycle while the matrix receiver keeps up;
//   every cell rotates all three angles at once and hands its vector to
//   the next cell every cycle unless the stage after it is stalled.
// Reset: rst_n clears every stage valid bit asynchronously; the pipe comes out empty.
// Back pressure:
//   Every stage holds its request while the stage after it is full and
//   stalled, and empty stages keep filling, so ready on the angles channel
//   only drops once the whole pipe is full behind a stalled receiver.
`default_nettype none
module euler_rotation_matrix (
    input  wire logic    clk,
    input  wire logic    rst_n,
    erm_angle_if.sink    angles,
    erm_matrix_if.source matrix
);

    localparam int N = erm_pkg::NUM_CELLS;

    // Node k feeds cell k; node N feeds the combine stage.
    logic                  node_valid [N+1];
    logic                  node_ready [N+1];
    erm_pkg::cordic_trio_t node_data  [N+1];
    erm_pkg::elem_set_t    elems;

    erm_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (angles.valid),
        .in_ready  (angles.ready),
        .angle_x   (angles.angle_x),
        .angle_y   (angles.angle_y),
        .angle_z   (angles.angle_z),
        .out_valid (node_valid[0]),
        .out_ready (node_ready[0]),
        .out_data  (node_data[0])
    );

    // The rotation chain: cell i shifts by i and uses the i-th arctangent.
    for (genvar i = 0; i < N; i++) begin : g_cell
        erm_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (erm_pkg::IDX_W'(i)),
            .in_valid  (node_valid[i]),
            .in_ready  (node_ready[i]),
            .in_data   (node_data[i]),
            .out_valid (node_valid[i+1]),
            .out_ready (node_ready[i+1]),
            .out_data  (node_data[i+1])
        );
    end

    erm_combine u_combine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (node_valid[N]),
        .in_ready  (node_ready[N]),
        .in_data   (node_data[N]),
        .out_valid (matrix.valid),
        .out_ready (matrix.ready),
        .out_data  (elems)
    );

    assign matrix.elem_00 = elems.e00;
    assign matrix.elem_01 = elems.e01;
    assign matrix.elem_02 = elems.e02;
    assign matrix.elem_10 = elems.e10;
    assign matrix.elem_11 = elems.e11;
    assign matrix.elem_12 = elems.e12;
    assign matrix.elem_20 = elems.e20;
    assign matrix.elem_21 = elems.e21;
    assign matrix.elem_22 = elems.e22;

    // An empty output stage must never hold back the chain.
    a_combine_open: assert property (@(posedge clk) disable iff (!rst_n)
        !matrix.valid |-> node_ready[N])
        else $error("combine stage stalled with empty output");

    // An empty reduce output stage never blocks the angles channel.
    a_head_open: assert property (@(posedge clk) disable iff (!rst_n)
        !node_valid[0] |-> angles.ready)
        else $error("angles channel stalled with empty reduce stage");

    // Saturation keeps every delivered element within plus or minus one; this checks elem_00 and elem_22.
    a_elem_range: assert property (@(posedge clk) disable iff (!rst_n)
        matrix.valid |->
            ($signed(matrix.elem_00) <= 16'sd16384 && $signed(matrix.elem_00) >= -16'sd16384
          && $signed(matrix.elem_22) <= 16'sd16384 && $signed(matrix.elem_22) >= -16'sd16384))
        else $error("matrix element out of range");

    // The pipe comes out of reset empty.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !matrix.valid)
        else $error("result valid right after reset");

endmodule
`default_nettype wire
